// ----- hw/rtl/buddy_frame_allocator_macros.svh -----
// ----------------------------------------------------------------------------
// Buddy frame allocator assertion macros
// Shared concurrent assertion forms used by the allocator controller.
// ----------------------------------------------------------------------------
`ifndef BUDDY_FRAME_ALLOCATOR_MACROS_SVH
`define BUDDY_FRAME_ALLOCATOR_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BFA_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define BFA_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hw/rtl/bfa_pkg.sv -----
// ----------------------------------------------------------------------------
// Buddy frame allocator package
// Shared widths, register indexes, controller states, datapath operations
// and the status bundle passed from datapath to controller.
// ----------------------------------------------------------------------------
`default_nettype none

package bfa_pkg;

  localparam int FRAME_W = 20;
  localparam int CFG_W   = 21;
  localparam int CNT_W   = 17;
  localparam int ORD_W   = 4;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  localparam logic REG_BASE = 1'b0;
  localparam logic REG_TOP  = 1'b1;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  typedef enum logic [4:0] {
    S_CLR,
    S_IDLE,
    S_DISP,
    S_SCAN,
    S_POP,
    S_SPLIT,
    S_ADONE,
    S_FDEC,
    S_MBUD,
    S_MBUDD,
    S_WALK,
    S_WALKW,
    S_UNLINK,
    S_PUSH,
    S_FAIL
  } state_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_CLR,
    OP_LOAD,
    OP_SCAN,
    OP_POPRD,
    OP_POP,
    OP_SPLIT,
    OP_ALLOC_DONE,
    OP_FAIL,
    OP_MRD_FRAME,
    OP_MRD_BUD,
    OP_WSTART,
    OP_WSTEP,
    OP_WLOAD,
    OP_URD,
    OP_UNLINK,
    OP_PUSH
  } op_t;

  typedef struct packed {
    logic clr_last;
    logic bad_order;
    logic is_free;
    logic o_over;
    logic cnt_zero;
    logic o_gt_order;
    logic o_top;
    logic frame_ok;
    logic bud_ok;
    logic mark_set;
    logic walk_end;
    logic cur_is_bud;
    logic out_busy;
  } status_t;

endpackage

`default_nettype wire

// ----- hw/rtl/buddy_frame_allocator.sv -----
// ----------------------------------------------------------------------------
// Buddy frame allocator
// Buddy allocation over frames in a configured window with per-order LIFO
// free lists, per-order free marks and a free-page count.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake            Contents
//  cfg      in         cfg_we               cfg_index, cfg_wdata
//  in       in         in_valid / in_stall  in_cmd, in_order, in_frame
//  out      out        out_valid/out_stall  out_alloc_frame, out_failed,
//                                           out_free_pages
//
// An allocation scans the orders upward for a non-empty list, pops its head and
// splits down to the requested order. A free merges with each free buddy, found
// by a walk over that order's list in the link memory, and then pushes the block.
// After reset a clearing pass over the whole mark memory clears the marks.
// One transaction is in work at a time; a stalled result holds the finish step.
// ----------------------------------------------------------------------------
`default_nettype none

module buddy_frame_allocator
  import bfa_pkg::*;
#(
  parameter int ORDERS     = 11,
  parameter int MAX_FRAMES = 65536
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_we,
  input  wire logic               cfg_index,
  input  wire logic [CFG_W-1:0]   cfg_wdata,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic               in_cmd,
  input  wire logic [ORD_W-1:0]   in_order,
  input  wire logic [FRAME_W-1:0] in_frame,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [FRAME_W-1:0]      out_alloc_frame,
  output logic                    out_failed,
  output logic [CNT_W-1:0]        out_free_pages
);

  op_t     op;
  status_t st;

  bfa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .op       (op)
  );

  bfa_datapath #(
    .ORDERS     (ORDERS),
    .MAX_FRAMES (MAX_FRAMES)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_cmd          (in_cmd),
    .in_order        (in_order),
    .in_frame        (in_frame),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_alloc_frame (out_alloc_frame),
    .out_failed      (out_failed),
    .out_free_pages  (out_free_pages),
    .op              (op),
    .st              (st)
  );

endmodule

`default_nettype wire

// ----- hw/rtl/bfa_datapath.sv -----
// ----------------------------------------------------------------------------
// Buddy frame allocator datapath
// Configuration, list heads and counts, link and free-mark memories, walk
// registers and the output register, driven by one operation per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module bfa_datapath
  import bfa_pkg::*;
#(
  parameter int ORDERS     = 11,
  parameter int MAX_FRAMES = 65536
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_we,
  input  wire logic               cfg_index,
  input  wire logic [CFG_W-1:0]   cfg_wdata,
  input  wire logic               in_cmd,
  input  wire logic [ORD_W-1:0]   in_order,
  input  wire logic [FRAME_W-1:0] in_frame,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [FRAME_W-1:0]      out_alloc_frame,
  output logic                    out_failed,
  output logic [CNT_W-1:0]        out_free_pages,
  input  wire op_t                op,
  output status_t                 st
);

  localparam int RW     = $clog2(MAX_FRAMES);
  localparam int MDEPTH = 2 * MAX_FRAMES + ORDERS;
  localparam int MW     = $clog2(MDEPTH);
  localparam int OW     = $clog2(ORDERS + 1);
  localparam int OIW    = $clog2(ORDERS);

  function automatic logic [MW-1:0] mark_base(input int o);
    int acc;
    acc = 0;
    for (int k = 0; k < o; k++) begin
      acc += ((MAX_FRAMES - 1) >> k) + 1;
    end
    return MW'(acc);
  endfunction

  function automatic logic [RW:0] rel_of(input logic [FRAME_W-1:0] f,
                                          input logic [CFG_W-1:0] base);
    logic [CFG_W-1:0] diff;
    diff = CFG_W'(f) - base;
    return {diff < CFG_W'(MAX_FRAMES), diff[RW-1:0]};
  endfunction

  function automatic logic block_ok(input logic [FRAME_W-1:0] f, input logic [OW-1:0] o,
                                    input logic [CFG_W-1:0] base,
                                    input logic [CFG_W-1:0] top);
    logic [CFG_W:0] sz;
    logic [CFG_W:0] fx;
    sz = (CFG_W+1)'(1) << o;
    fx = (CFG_W+1)'(f);
    return (CFG_W'(f) >= base) && (fx + sz <= (CFG_W+1)'(top)) &&
           (fx - (CFG_W+1)'(base) + sz <= (CFG_W+1)'(MAX_FRAMES));
  endfunction

  logic [MW-1:0] off_tab [ORDERS];

  for (genvar g = 0; g < ORDERS; g++) begin : g_off
    assign off_tab[g] = mark_base(g);
  end

  logic [CFG_W-1:0]   base_r, top_r;
  logic [FRAME_W-1:0] heads_r [ORDERS];
  logic [FRAME_W-1:0] heads_nxt [ORDERS];
  logic [CNT_W-1:0]   counts_r [ORDERS];
  logic [CNT_W-1:0]   counts_nxt [ORDERS];
  logic [CNT_W-1:0]   fpc_r, fpc_nxt;
  logic [MW-1:0]      clr_r, clr_nxt;
  logic               out_valid_r, out_valid_nxt;

  logic               cmd_r, cmd_nxt;
  logic [ORD_W-1:0]   ord_r, ord_nxt;
  logic [FRAME_W-1:0] frame_r, frame_nxt;
  logic [OW-1:0]      o_r, o_nxt;
  logic [FRAME_W-1:0] addr_r, addr_nxt;
  logic [FRAME_W-1:0] cur_r, cur_nxt;
  logic [FRAME_W-1:0] prev_r, prev_nxt;
  logic               first_r, first_nxt;
  logic [CNT_W-1:0]   i_r, i_nxt;
  logic [FRAME_W-1:0] out_frame_r, out_frame_nxt;
  logic               out_failed_r, out_failed_nxt;
  logic [CNT_W-1:0]   out_pages_r, out_pages_nxt;

  logic [FRAME_W-1:0] link_mem [MAX_FRAMES];
  logic               mark_mem [MDEPTH];
  logic [FRAME_W-1:0] lnk_q;
  logic               lnk_ok_r;
  logic               mk_q;

  logic               lk_we;
  logic [FRAME_W-1:0] lk_wf, lk_wdata, lk_rf;
  logic [RW:0]        lk_wrel, lk_rrel;
  logic               mk_we, mk_wdata, mk_clr;
  logic [OW-1:0]      mk_wo, mk_ro;
  logic [FRAME_W-1:0] mk_wf, mk_rf;
  logic [RW:0]        mk_wrel, mk_rrel;
  logic [MW-1:0]      mk_waddr, mk_raddr;

  logic [OIW-1:0]     o_i, o_dec_i;
  logic [OW-1:0]      o_dec;
  logic [FRAME_W-1:0] head_o, bud, lnk_val, split_f;
  logic [CNT_W-1:0]   cnt_o, ord_sz;
  logic [CNT_W:0]     fpc_sum;

  assign o_i     = o_r[OIW-1:0];
  assign o_dec   = o_r - OW'(1);
  assign o_dec_i = o_dec[OIW-1:0];
  assign head_o  = heads_r[o_i];
  assign cnt_o   = counts_r[o_i];
  assign bud     = frame_r ^ (FRAME_W'(1) << o_r);
  assign lnk_val = lnk_ok_r ? lnk_q : '0;
  assign split_f = addr_r + (FRAME_W'(1) << o_dec);
  assign ord_sz  = CNT_W'(1) << ord_r;
  assign fpc_sum = (CNT_W+1)'(fpc_r) + (CNT_W+1)'(ord_sz);

  always_comb begin
    heads_nxt     = heads_r;
    counts_nxt    = counts_r;
    fpc_nxt       = fpc_r;
    clr_nxt       = clr_r;
    cmd_nxt       = cmd_r;
    ord_nxt       = ord_r;
    frame_nxt     = frame_r;
    o_nxt         = o_r;
    addr_nxt      = addr_r;
    cur_nxt       = cur_r;
    prev_nxt      = prev_r;
    first_nxt     = first_r;
    i_nxt         = i_r;
    out_frame_nxt = out_frame_r;
    out_failed_nxt = out_failed_r;
    out_pages_nxt = out_pages_r;
    out_valid_nxt = out_valid_r && out_stall;
    lk_we         = 1'b0;
    lk_wf         = frame_r;
    lk_wdata      = head_o;
    lk_rf         = head_o;
    mk_we         = 1'b0;
    mk_clr        = 1'b0;
    mk_wdata      = 1'b0;
    mk_wo         = o_r;
    mk_wf         = frame_r;
    mk_ro         = o_r;
    mk_rf         = frame_r;
    case (op)
      OP_CLR: begin
        mk_we   = 1'b1;
        mk_clr  = 1'b1;
        clr_nxt = clr_r + MW'(1);
      end
      OP_LOAD: begin
        cmd_nxt   = in_cmd;
        ord_nxt   = in_order;
        frame_nxt = in_frame;
        o_nxt     = OW'(in_order);
      end
      OP_SCAN: begin
        o_nxt = o_r + OW'(1);
      end
      OP_POPRD: begin
        addr_nxt = head_o;
        lk_rf    = head_o;
      end
      OP_POP: begin
        heads_nxt[o_i]  = lnk_val;
        counts_nxt[o_i] = (cnt_o == '0) ? cnt_o : cnt_o - CNT_W'(1);
        mk_we    = 1'b1;
        mk_wo    = o_r;
        mk_wf    = addr_r;
      end
      OP_SPLIT: begin
        lk_we               = 1'b1;
        lk_wf               = split_f;
        lk_wdata            = heads_r[o_dec_i];
        heads_nxt[o_dec_i]  = split_f;
        counts_nxt[o_dec_i] = (counts_r[o_dec_i] == CNT_MAX) ? CNT_MAX :
                              counts_r[o_dec_i] + CNT_W'(1);
        mk_we    = 1'b1;
        mk_wdata = 1'b1;
        mk_wo    = o_dec;
        mk_wf    = split_f;
        o_nxt    = o_dec;
      end
      OP_ALLOC_DONE: begin
        fpc_nxt        = (fpc_r >= ord_sz) ? fpc_r - ord_sz : '0;
        out_frame_nxt  = addr_r;
        out_failed_nxt = 1'b0;
        out_pages_nxt  = fpc_nxt;
        out_valid_nxt  = 1'b1;
      end
      OP_FAIL: begin
        out_frame_nxt  = '0;
        out_failed_nxt = 1'b1;
        out_pages_nxt  = fpc_r;
        out_valid_nxt  = 1'b1;
      end
      OP_MRD_FRAME: begin
        mk_ro = o_r;
        mk_rf = frame_r;
      end
      OP_MRD_BUD: begin
        mk_ro = o_r;
        mk_rf = bud;
      end
      OP_WSTART: begin
        cur_nxt   = head_o;
        prev_nxt  = '0;
        first_nxt = 1'b1;
        i_nxt     = '0;
      end
      OP_WSTEP: begin
        prev_nxt  = cur_r;
        first_nxt = 1'b0;
        lk_rf     = cur_r;
        i_nxt     = i_r + CNT_W'(1);
      end
      OP_WLOAD: begin
        cur_nxt = lnk_val;
      end
      OP_URD: begin
        lk_rf = bud;
      end
      OP_UNLINK: begin
        if (first_r) begin
          heads_nxt[o_i] = lnk_val;
        end else begin
          lk_we    = 1'b1;
          lk_wf    = prev_r;
          lk_wdata = lnk_val;
        end
        counts_nxt[o_i] = (cnt_o == '0) ? cnt_o : cnt_o - CNT_W'(1);
        mk_we = 1'b1;
        mk_wo = o_r;
        mk_wf = bud;
        if (bud < frame_r) begin
          frame_nxt = bud;
        end
        o_nxt = o_r + OW'(1);
      end
      OP_PUSH: begin
        lk_we           = 1'b1;
        lk_wf           = frame_r;
        lk_wdata        = head_o;
        heads_nxt[o_i]  = frame_r;
        counts_nxt[o_i] = (cnt_o == CNT_MAX) ? CNT_MAX : cnt_o + CNT_W'(1);
        mk_we    = 1'b1;
        mk_wdata = 1'b1;
        mk_wo    = o_r;
        mk_wf    = frame_r;
        fpc_nxt  = fpc_sum[CNT_W] ? CNT_MAX : fpc_sum[CNT_W-1:0];
        out_frame_nxt  = '0;
        out_failed_nxt = 1'b0;
        out_pages_nxt  = fpc_nxt;
        out_valid_nxt  = 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign lk_wrel  = rel_of(lk_wf, base_r);
  assign lk_rrel  = rel_of(lk_rf, base_r);
  assign mk_wrel  = rel_of(mk_wf, base_r);
  assign mk_rrel  = rel_of(mk_rf, base_r);
  assign mk_waddr = mk_clr ? clr_r :
                    off_tab[mk_wo[OIW-1:0]] + MW'(mk_wrel[RW-1:0] >> mk_wo);
  assign mk_raddr = off_tab[mk_ro[OIW-1:0]] + MW'(mk_rrel[RW-1:0] >> mk_ro);

  always_ff @(posedge clk) begin
    if (lk_we && lk_wrel[RW]) begin
      link_mem[lk_wrel[RW-1:0]] <= lk_wdata;
    end
    lnk_q    <= link_mem[lk_rrel[RW-1:0]];
    lnk_ok_r <= lk_rrel[RW];
  end

  always_ff @(posedge clk) begin
    if (mk_we && (mk_clr || mk_wrel[RW])) begin
      mark_mem[mk_waddr] <= mk_wdata;
    end
    mk_q <= mark_mem[mk_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r      <= '0;
      top_r       <= '0;
      fpc_r       <= '0;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
      for (int k = 0; k < ORDERS; k++) begin
        heads_r[k]  <= '0;
        counts_r[k] <= '0;
      end
    end else begin
      if (cfg_we && cfg_index == REG_BASE) begin
        base_r <= cfg_wdata;
      end
      if (cfg_we && cfg_index == REG_TOP) begin
        top_r <= cfg_wdata;
      end
      fpc_r       <= fpc_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
      heads_r     <= heads_nxt;
      counts_r    <= counts_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    ord_r        <= ord_nxt;
    frame_r      <= frame_nxt;
    o_r          <= o_nxt;
    addr_r       <= addr_nxt;
    cur_r        <= cur_nxt;
    prev_r       <= prev_nxt;
    first_r      <= first_nxt;
    i_r          <= i_nxt;
    out_frame_r  <= out_frame_nxt;
    out_failed_r <= out_failed_nxt;
    out_pages_r  <= out_pages_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_alloc_frame = out_frame_r;
  assign out_failed      = out_failed_r;
  assign out_free_pages  = out_pages_r;

  always_comb begin
    st.clr_last   = (clr_r == MW'(MDEPTH - 1));
    st.bad_order  = ({1'b0, ord_r} >= (ORD_W+1)'(ORDERS));
    st.is_free    = (cmd_r == CMD_FREE);
    st.o_over     = (o_r >= OW'(ORDERS));
    st.cnt_zero   = (cnt_o == '0);
    st.o_gt_order = (o_r > OW'(ord_r));
    st.o_top      = (o_r == OW'(ORDERS - 1));
    st.frame_ok   = block_ok(frame_r, o_r, base_r, top_r);
    st.bud_ok     = block_ok(bud, o_r, base_r, top_r);
    st.mark_set   = mk_q;
    st.walk_end   = (i_r >= cnt_o);
    st.cur_is_bud = (cur_r == bud);
    st.out_busy   = out_valid_r && out_stall;
  end

endmodule

`default_nettype wire

// ----- hw/rtl/bfa_ctrl.sv -----
// ----------------------------------------------------------------------------
// Buddy frame allocator controller
// Sequences the mark clearing pass, allocation scan and split, and the free
// check, buddy walk, unlink and push, one datapath operation per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

`include "buddy_frame_allocator_macros.svh"

module bfa_ctrl
  import bfa_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_valid,
  output logic         in_stall,
  input  wire status_t st,
  output op_t          op
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    op        = OP_NONE;
    in_stall  = (state_r != S_IDLE);
    unique case (state_r)
      S_CLR: begin
        op = OP_CLR;
        if (st.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          op        = OP_LOAD;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        if (st.bad_order) begin
          state_nxt = S_FAIL;
        end else if (!st.is_free) begin
          state_nxt = S_SCAN;
        end else begin
          op        = OP_MRD_FRAME;
          state_nxt = S_FDEC;
        end
      end
      S_SCAN: begin
        if (st.o_over) begin
          state_nxt = S_FAIL;
        end else if (st.cnt_zero) begin
          op = OP_SCAN;
        end else begin
          op        = OP_POPRD;
          state_nxt = S_POP;
        end
      end
      S_POP: begin
        op        = OP_POP;
        state_nxt = S_SPLIT;
      end
      S_SPLIT: begin
        if (st.o_gt_order) begin
          op = OP_SPLIT;
        end else begin
          state_nxt = S_ADONE;
        end
      end
      S_ADONE: begin
        if (!st.out_busy) begin
          op        = OP_ALLOC_DONE;
          state_nxt = S_IDLE;
        end
      end
      S_FDEC: begin
        if (!st.frame_ok || st.mark_set) begin
          state_nxt = S_FAIL;
        end else begin
          state_nxt = S_MBUD;
        end
      end
      S_MBUD: begin
        if (st.o_top || !st.bud_ok) begin
          state_nxt = S_PUSH;
        end else begin
          op        = OP_MRD_BUD;
          state_nxt = S_MBUDD;
        end
      end
      S_MBUDD: begin
        if (!st.mark_set) begin
          state_nxt = S_PUSH;
        end else begin
          op        = OP_WSTART;
          state_nxt = S_WALK;
        end
      end
      S_WALK: begin
        if (st.walk_end) begin
          state_nxt = S_PUSH;
        end else if (st.cur_is_bud) begin
          op        = OP_URD;
          state_nxt = S_UNLINK;
        end else begin
          op        = OP_WSTEP;
          state_nxt = S_WALKW;
        end
      end
      S_WALKW: begin
        op        = OP_WLOAD;
        state_nxt = S_WALK;
      end
      S_UNLINK: begin
        op        = OP_UNLINK;
        state_nxt = S_MBUD;
      end
      S_PUSH: begin
        if (!st.out_busy) begin
          op        = OP_PUSH;
          state_nxt = S_IDLE;
        end
      end
      S_FAIL: begin
        if (!st.out_busy) begin
          op        = OP_FAIL;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  `BFA_ASSERT_NXT(a_accept_dispatch, clk, rst_n, in_valid && !in_stall, state_r == S_DISP, "accepted transaction did not dispatch")
  `BFA_ASSERT_IMP(a_unlink_found, clk, rst_n, state_r == S_UNLINK, st.cur_is_bud && !st.walk_end, "unlink without a found buddy")
  `BFA_ASSERT_IMP(a_result_room, clk, rst_n, op == OP_FAIL || op == OP_PUSH || op == OP_ALLOC_DONE, !st.out_busy, "result loaded over a waiting transaction")

endmodule

`default_nettype wire
